FILE: hw/rtl/auto_reload_timer_bank_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the timer bank
// Concurrent checks sampled on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef AUTO_RELOAD_TIMER_BANK_DEFINES_SVH
`define AUTO_RELOAD_TIMER_BANK_DEFINES_SVH

// A property that must hold at every rising edge outside of reset.
`define ARTB_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("timer bank assertion failed");

// An antecedent that, when true, requires the consequent in the same cycle.
`define ARTB_ASSERT_IMP(lbl, ante, cons) \
    `ARTB_ASSERT(lbl, (ante) |-> (cons))

`endif

FILE: hw/rtl/artb_pkg.sv
// ----------------------------------------------------------------------------
// artb_pkg
// Shared widths, operation codes and types of the timer bank.
// ----------------------------------------------------------------------------
package artb_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int FUNC_W         = 3;
    localparam int ID_W           = 4;
    localparam int CNT_W          = 16;

    localparam logic [FUNC_W-1:0] FN_SET   = 3'd0;
    localparam logic [FUNC_W-1:0] FN_START = 3'd1;
    localparam logic [FUNC_W-1:0] FN_STOP  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_READ  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_TICK  = 3'd4;

    localparam logic KIND_READ   = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

    // Result of the shared count unit for the timer under service.
    typedef struct packed {
        logic [CNT_W-1:0] cur_count;
        logic [CNT_W-1:0] next_count;
        logic             expired;
    } artb_step_t;

endpackage

FILE: hw/rtl/artb_ram.sv
// ----------------------------------------------------------------------------
// artb_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module artb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/artb_step.sv
// ----------------------------------------------------------------------------
// artb_step
// Shared count unit: masks unwritten entries, increments and compares.
// ----------------------------------------------------------------------------
module artb_step
    import artb_pkg::*;
(
    input  logic [CNT_W-1:0] count,
    input  logic             count_ok,
    input  logic [CNT_W-1:0] period,
    input  logic             period_ok,
    output artb_step_t       step
);

    logic [CNT_W-1:0] cur;
    logic [CNT_W-1:0] per;
    logic [CNT_W-1:0] inc;

    // Entries never written read as zero, as after reset.
    assign cur = count_ok ? count : '0;
    assign per = period_ok ? period : '0;
    assign inc = cur + CNT_W'(1);

    assign step.cur_count  = cur;
    assign step.expired    = (inc == per);
    assign step.next_count = (inc == per) ? '0 : inc;

endmodule

FILE: hw/rtl/auto_reload_timer_bank.sv
// ----------------------------------------------------------------------------
// auto_reload_timer_bank
// Bank of auto-reload tick timers with set, start, stop, read and tick.
// ----------------------------------------------------------------------------
// Usage:
// Command words arrive on cmd_valid/cmd_stall with func, timer_id and period.
// Result words leave on rsp_valid/rsp_stall with kind, which_timer,
// count_value and last. A word moves on an edge with valid high, stall low.
// Set, start and stop complete in the accept cycle and the next command can
// follow immediately. A read gives one reply word with last set. A tick
// walks all NUM_TIMERS timers through the single read port of the count
// memory, one timer per cycle unless it waits on a stalled receiver, and
// takes no new command until the walk and its flush state end. Expiry
// words come out in ascending timer order; the last one of a tick has last
// set, so the final expiry is held until the walk has finished.
// A result register sits on the output, so a stalled receiver only holds the
// block up when a second word is ready while the first is still waiting.
// Reset stops all timers and marks every count and period entry unwritten,
// so they read as zero; no clearing pass is needed and commands are taken
// in the first cycle after reset.
// ----------------------------------------------------------------------------
`include "auto_reload_timer_bank_defines.svh"

module auto_reload_timer_bank
    import artb_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  logic [FUNC_W-1:0] func,
    input  logic [ID_W-1:0]   timer_id,
    input  logic [CNT_W-1:0]  period,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output logic              kind,
    output logic [ID_W-1:0]   which_timer,
    output logic [CNT_W-1:0]  count_value,
    output logic              last
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int WID_W = (IDX_W > ID_W) ? IDX_W : ID_W;
    localparam logic [IDX_W-1:0] SCAN_END = IDX_W'(NUM_TIMERS - 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_READ  = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_FLUSH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [IDX_W-1:0]      scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0]      op_idx_reg, op_idx_next;
    logic [ID_W-1:0]       op_id_reg, op_id_next;
    logic                  op_ok_reg, op_ok_next;
    logic                  pend_vld_reg, pend_vld_next;
    logic [IDX_W-1:0]      pend_idx_reg, pend_idx_next;
    logic [NUM_TIMERS-1:0] running_reg, running_next;
    logic [NUM_TIMERS-1:0] cnt_vld_reg, cnt_vld_next;
    logic [NUM_TIMERS-1:0] per_vld_reg, per_vld_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  kind_reg, kind_next;
    logic [ID_W-1:0]       which_reg, which_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  last_reg, last_next;

    logic [WID_W-1:0] id_wide;
    logic [IDX_W-1:0] id_idx;
    logic             id_ok;
    logic             out_free;

    logic             cnt_we;
    logic [IDX_W-1:0] cnt_waddr;
    logic [CNT_W-1:0] cnt_wdata;
    logic             per_we;
    logic [IDX_W-1:0] raddr;
    logic [CNT_W-1:0] cnt_rdata;
    logic [CNT_W-1:0] per_rdata;
    logic [IDX_W-1:0] cur_idx;
    artb_step_t       step;

    logic             run;
    logic             expire;
    logic             hold;

    // The timer index is widened first so that banks above sixteen timers
    // still get a full index; timer_id can only reach the first sixteen.
    assign id_wide = WID_W'(timer_id);
    assign id_idx  = id_wide[IDX_W-1:0];
    assign id_ok   = (32'(timer_id) < 32'(NUM_TIMERS));

    assign cmd_stall = (state_reg != ST_IDLE);
    assign out_free  = !out_valid_reg || !rsp_stall;

    artb_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NUM_TIMERS)
    ) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (raddr),
        .rdata (cnt_rdata)
    );

    artb_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NUM_TIMERS)
    ) u_period_ram (
        .clk   (clk),
        .we    (per_we),
        .waddr (id_idx),
        .wdata (period),
        .raddr (raddr),
        .rdata (per_rdata)
    );

    assign cur_idx = (state_reg == ST_READ) ? op_idx_reg : scan_idx_reg;

    artb_step u_step (
        .count     (cnt_rdata),
        .count_ok  (cnt_vld_reg[cur_idx]),
        .period    (per_rdata),
        .period_ok (per_vld_reg[cur_idx]),
        .step      (step)
    );

    // During the walk a new expiry can only be recorded once the previous
    // one has been handed to the result register; otherwise the walk waits
    // on the current timer, whose memory word stays on the read port.
    assign run    = running_reg[scan_idx_reg];
    assign expire = run && step.expired;
    assign hold   = expire && pend_vld_reg && !out_free;

    always_comb
    begin
        state_next     = state_reg;
        scan_idx_next  = scan_idx_reg;
        op_idx_next    = op_idx_reg;
        op_id_next     = op_id_reg;
        op_ok_next     = op_ok_reg;
        pend_vld_next  = pend_vld_reg;
        pend_idx_next  = pend_idx_reg;
        running_next   = running_reg;
        cnt_vld_next   = cnt_vld_reg;
        per_vld_next   = per_vld_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        kind_next      = kind_reg;
        which_next     = which_reg;
        count_next     = count_reg;
        last_next      = last_reg;
        cnt_we         = 1'b0;
        cnt_waddr      = scan_idx_reg;
        cnt_wdata      = step.next_count;
        per_we         = 1'b0;
        raddr          = scan_idx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                raddr = (func == FN_TICK) ? '0 : id_idx;
                if (cmd_valid)
                begin
                    case (func)
                        FN_SET:
                        begin
                            // Loading a running timer or a zero period is refused.
                            if (id_ok && !running_reg[id_idx] && (period != '0))
                            begin
                                cnt_we               = 1'b1;
                                cnt_waddr            = id_idx;
                                cnt_wdata            = '0;
                                per_we               = 1'b1;
                                cnt_vld_next[id_idx] = 1'b1;
                                per_vld_next[id_idx] = 1'b1;
                            end
                        end
                        FN_START:
                        begin
                            if (id_ok)
                            begin
                                running_next[id_idx] = 1'b1;
                            end
                        end
                        FN_STOP:
                        begin
                            if (id_ok)
                            begin
                                running_next[id_idx] = 1'b0;
                            end
                        end
                        FN_READ:
                        begin
                            op_idx_next = id_idx;
                            op_id_next  = timer_id;
                            op_ok_next  = id_ok;
                            state_next  = ST_READ;
                        end
                        FN_TICK:
                        begin
                            scan_idx_next = '0;
                            pend_vld_next = 1'b0;
                            state_next    = ST_SCAN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                raddr = op_idx_reg;
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_READ;
                    which_next     = op_id_reg;
                    count_next     = op_ok_reg ? step.cur_count : '0;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (!hold)
                begin
                    raddr = scan_idx_reg + IDX_W'(1);
                    if (run)
                    begin
                        cnt_we                     = 1'b1;
                        cnt_vld_next[scan_idx_reg] = 1'b1;
                    end
                    if (expire)
                    begin
                        if (pend_vld_reg)
                        begin
                            out_valid_next = 1'b1;
                            kind_next      = KIND_EXPIRY;
                            which_next     = ID_W'(pend_idx_reg);
                            count_next     = '0;
                            last_next      = 1'b0;
                        end
                        pend_vld_next = 1'b1;
                        pend_idx_next = scan_idx_reg;
                    end
                    if (scan_idx_reg == SCAN_END)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        scan_idx_next = scan_idx_reg + IDX_W'(1);
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!pend_vld_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_EXPIRY;
                    which_next     = ID_W'(pend_idx_reg);
                    count_next     = '0;
                    last_next      = 1'b1;
                    pend_vld_next  = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_idx_reg  <= '0;
            pend_vld_reg  <= 1'b0;
            running_reg   <= '0;
            cnt_vld_reg   <= '0;
            per_vld_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_idx_reg  <= scan_idx_next;
            pend_vld_reg  <= pend_vld_next;
            running_reg   <= running_next;
            cnt_vld_reg   <= cnt_vld_next;
            per_vld_reg   <= per_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_idx_reg   <= op_idx_next;
        op_id_reg    <= op_id_next;
        op_ok_reg    <= op_ok_next;
        pend_idx_reg <= pend_idx_next;
        kind_reg     <= kind_next;
        which_reg    <= which_next;
        count_reg    <= count_next;
        last_reg     <= last_next;
    end

    assign rsp_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign which_timer = which_reg;
    assign count_value = count_reg;
    assign last        = last_reg;

    `ARTB_ASSERT_IMP(a_read_reply_last, rsp_valid && (kind == KIND_READ), last)
    `ARTB_ASSERT_IMP(a_expiry_zero_count, rsp_valid && (kind == KIND_EXPIRY), count_value == '0)
    `ARTB_ASSERT(a_flush_ends, (state_reg == ST_FLUSH && out_free) |=> (state_reg == ST_IDLE))
    `ARTB_ASSERT_IMP(a_scan_in_range, state_reg == ST_SCAN, 32'(scan_idx_reg) < 32'(NUM_TIMERS))

endmodule

FILE: tb/sv/auto_reload_timer_bank_test.sv
// ----------------------------------------------------------------------------
// auto_reload_timer_bank_test
// Self-checking bench for the auto-reload timer bank. A queue of command
// words, filled up front by a directed list and by random traffic, feeds a
// clocked driver. A clocked monitor compares every result word with the words
// that the bench's own timer model works out when each command is accepted.
// Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module auto_reload_timer_bank_test
    import artb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NT          = NUM_TIMERS_DEF;
    localparam int RAND_ITEMS  = 246;
    localparam int DRAIN_CYC   = 60;
    localparam int CYCLE_LIMIT = 1_000_000;

    // One command word as the driver presents it.
    typedef struct {
        logic [FUNC_W-1:0] func;
        logic [ID_W-1:0]   timer_id;
        logic [CNT_W-1:0]  period;
    } timer_cmd_t;

    // One result word as the monitor sees it.
    typedef struct {
        logic             kind;
        logic [ID_W-1:0]  which_timer;
        logic [CNT_W-1:0] count_value;
        logic             last;
    } timer_word_t;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              cmd_valid   = 1'b0;
    logic              cmd_stall;
    logic [FUNC_W-1:0] func        = '0;
    logic [ID_W-1:0]   timer_id    = '0;
    logic [CNT_W-1:0]  period      = '0;
    logic              rsp_valid;
    logic              rsp_stall   = 1'b0;
    logic              kind;
    logic [ID_W-1:0]   which_timer;
    logic [CNT_W-1:0]  count_value;
    logic              last;

    timer_cmd_t  cmd_q[$];
    timer_word_t expected_words[$];

    // The bench's own copy of the timer bank state.
    logic [CNT_W-1:0] model_count  [NT];
    logic [CNT_W-1:0] model_period [NT];
    logic             model_running[NT];

    int          n_queued      = 0;
    int          n_accepted    = 0;
    int          n_reads       = 0;
    int          n_expiries    = 0;
    int          widest_burst  = 0;
    int          err_cnt       = 0;
    int          cycle_cnt     = 0;
    int          gap_left      = 0;
    int          stall_left    = 0;

    // While calm is set neither side idles, so back-to-back words get tested.
    logic        calm          = 1'b0;

    auto_reload_timer_bank u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .func        (func),
        .timer_id    (timer_id),
        .period      (period),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .kind        (kind),
        .which_timer (which_timer),
        .count_value (count_value),
        .last        (last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Periods are kept small most of the time so that timers actually expire.
    function automatic logic [CNT_W-1:0] pick_period();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return CNT_W'($urandom_range(1, 6));
        if (r < 85)
            return CNT_W'($urandom_range(7, 40));
        if (r < 93)
            return CNT_W'($urandom);
        return '0;
    endfunction

    task automatic queue_cmd(input logic [FUNC_W-1:0] f, input logic [ID_W-1:0] id,
                             input logic [CNT_W-1:0] p);
        timer_cmd_t c;
        c.func     = f;
        c.timer_id = id;
        c.period   = p;
        cmd_q.push_back(c);
        n_queued++;
    endtask

    // Updates the timer model for one accepted command and queues the result
    // words that the command is due to produce.
    task automatic predict_timer_words(input timer_cmd_t c);
        timer_word_t w;
        logic        fired[NT];
        int          final_idx;
        int          burst;
        final_idx = -1;
        burst     = 0;
        case (c.func)
            FN_SET:
            begin
                // A running timer or a zero period leaves the entry untouched.
                if (!model_running[c.timer_id] && c.period != '0)
                begin
                    model_count[c.timer_id]  = '0;
                    model_period[c.timer_id] = c.period;
                end
            end
            FN_START:
                model_running[c.timer_id] = 1'b1;
            FN_STOP:
                model_running[c.timer_id] = 1'b0;
            FN_READ:
            begin
                w.kind        = KIND_READ;
                w.which_timer = c.timer_id;
                w.count_value = model_count[c.timer_id];
                w.last        = 1'b1;
                expected_words.push_back(w);
            end
            FN_TICK:
            begin
                // First pass advances the counts and notes which ones wrapped,
                // so that the highest wrapping index can carry last.
                for (int i = 0; i < NT; i++)
                begin
                    fired[i] = 1'b0;
                    if (model_running[i])
                    begin
                        model_count[i] = model_count[i] + 1'b1;
                        if (model_count[i] == model_period[i])
                        begin
                            model_count[i] = '0;
                            fired[i]       = 1'b1;
                            final_idx      = i;
                        end
                    end
                end
                for (int i = 0; i < NT; i++)
                begin
                    if (fired[i])
                    begin
                        w.kind        = KIND_EXPIRY;
                        w.which_timer = ID_W'(i);
                        w.count_value = '0;
                        w.last        = (i == final_idx);
                        expected_words.push_back(w);
                        burst++;
                    end
                end
                if (burst > widest_burst)
                    widest_burst = burst;
            end
            default:
                ; // Unused codes are dropped by the block.
        endcase
    endtask

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
            err_cnt++;
        end
    endtask

    // Driver: presents queued command words. A stalled word is held as it is;
    // after each accepted word it may idle for a random number of cycles.
    always @(posedge clk or negedge rst_n)
    begin
        timer_cmd_t c;
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            gap_left  <= 0;
        end
        else
        begin
            if (cmd_valid && !cmd_stall)
            begin
                c.func     = func;
                c.timer_id = timer_id;
                c.period   = period;
                predict_timer_words(c);
                n_accepted <= n_accepted + 1;
                if (n_accepted % 40 == 39)
                    calm <= ($urandom_range(0, 2) == 0);
            end
            if (cmd_valid && cmd_stall)
                ; // Hold the stalled word.
            else if (gap_left > 0)
            begin
                cmd_valid <= 1'b0;
                gap_left  <= gap_left - 1;
            end
            else if (cmd_q.size() > 0)
            begin
                c = cmd_q.pop_front();
                func      <= c.func;
                timer_id  <= c.timer_id;
                period    <= c.period;
                cmd_valid <= 1'b1;
                gap_left  <= pick_gap();
            end
            else
                cmd_valid <= 1'b0;
        end
    end

    // Monitor: takes result words under a random stall and checks each one
    // against the oldest expected word.
    always @(posedge clk or negedge rst_n)
    begin
        timer_word_t w;
        if (!rst_n)
        begin
            rsp_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("unexpected result word: kind %0d timer %0d count %0d last %0d",
                           kind, which_timer, count_value, last);
                    err_cnt++;
                end
                else
                begin
                    w = expected_words.pop_front();
                    check_field("kind", w.kind, kind);
                    check_field("which_timer", w.which_timer, which_timer);
                    check_field("count_value", w.count_value, count_value);
                    check_field("last", w.last, last);
                    if (w.kind == KIND_READ)
                        n_reads++;
                    else
                        n_expiries++;
                end
            end
            if (stall_left > 0)
            begin
                rsp_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else if (!calm && $urandom_range(0, 2) == 0)
            begin
                rsp_stall  <= 1'b1;
                stall_left <= pick_gap();
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
            @(posedge clk);
        $display("timeout after %0d cycles, %0d words still expected",
                 cycle_cnt, expected_words.size());
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        int r;
        int id;
        int rand_start;

        for (int i = 0; i < NT; i++)
        begin
            model_count[i]   = '0;
            model_period[i]  = '0;
            model_running[i] = 1'b0;
        end

        // Directed part. Reads straight after reset must return zero counts.
        queue_cmd(FN_READ,  4'd0,  16'd0);
        queue_cmd(FN_READ,  4'd15, 16'hFFFF);
        // A zero period is rejected, and a tick with nothing running is silent.
        queue_cmd(FN_SET,   4'd3,  16'd0);
        queue_cmd(FN_TICK,  4'd9,  16'h1234);
        queue_cmd(FN_SET,   4'd3,  16'd2);
        queue_cmd(FN_START, 4'd3,  16'd0);
        // Set on a running timer must be ignored, so the period stays 2.
        queue_cmd(FN_SET,   4'd3,  16'd9);
        queue_cmd(FN_TICK,  4'd0,  16'd0);
        queue_cmd(FN_READ,  4'd3,  16'd0);
        queue_cmd(FN_TICK,  4'd15, 16'hFFFF);
        queue_cmd(FN_READ,  4'd3,  16'd0);
        // Largest period, and a timer that runs without ever getting a period.
        queue_cmd(FN_SET,   4'd15, 16'hFFFF);
        queue_cmd(FN_START, 4'd15, 16'd0);
        queue_cmd(FN_START, 4'd0,  16'd0);
        queue_cmd(FN_TICK,  4'd0,  16'd0);
        queue_cmd(FN_TICK,  4'd0,  16'd0);
        queue_cmd(FN_READ,  4'd0,  16'd0);
        queue_cmd(FN_READ,  4'd15, 16'd0);
        // The three unused codes must produce nothing.
        queue_cmd(3'd5,     4'd15, 16'hFFFF);
        queue_cmd(3'd6,     4'd5,  16'h5555);
        queue_cmd(3'd7,     4'd10, 16'hAAAA);
        queue_cmd(FN_STOP,  4'd3,  16'd0);
        queue_cmd(FN_TICK,  4'd0,  16'd0);
        queue_cmd(FN_READ,  4'd3,  16'd0);

        rand_start = n_queued;

        // One full sweep brings every timer to period one, so the next tick
        // expires the whole bank in a single burst.
        for (int i = 0; i < NT; i++)
        begin
            queue_cmd(FN_STOP,  ID_W'(i), CNT_W'($urandom));
            queue_cmd(FN_SET,   ID_W'(i), 16'd1);
            queue_cmd(FN_START, ID_W'(i), CNT_W'($urandom));
        end
        queue_cmd(FN_TICK, ID_W'($urandom), CNT_W'($urandom));
        queue_cmd(FN_TICK, ID_W'($urandom), CNT_W'($urandom));

        // Random part: mostly reprogram sequences and ticks, some noise.
        while (n_queued - rand_start < RAND_ITEMS)
        begin
            r  = $urandom_range(0, 99);
            id = $urandom_range(0, NT - 1);
            if (r < 30)
                queue_cmd(FN_TICK, ID_W'($urandom), CNT_W'($urandom));
            else if (r < 45)
                queue_cmd(FN_READ, ID_W'(id), CNT_W'($urandom));
            else if (r < 65)
            begin
                queue_cmd(FN_STOP,  ID_W'(id), CNT_W'($urandom));
                queue_cmd(FN_SET,   ID_W'(id), pick_period());
                queue_cmd(FN_START, ID_W'(id), CNT_W'($urandom));
            end
            else if (r < 75)
                queue_cmd(FN_SET, ID_W'(id), pick_period());
            else if (r < 83)
                queue_cmd(FN_START, ID_W'(id), CNT_W'($urandom));
            else if (r < 91)
                queue_cmd(FN_STOP, ID_W'(id), CNT_W'($urandom));
            else if (r < 96)
            begin
                repeat ($urandom_range(3, 10))
                    queue_cmd(FN_TICK, ID_W'($urandom), CNT_W'($urandom));
            end
            else
                queue_cmd(FUNC_W'($urandom), ID_W'($urandom), CNT_W'($urandom));
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for the last command to go in, then for the last result.
        while (n_accepted < n_queued)
            @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
        // A final tick may still be walking the bank; give it time to show any
        // stray word.
        repeat (DRAIN_CYC) @(posedge clk);

        if (expected_words.size() != 0)
        begin
            $error("%0d expected words never arrived", expected_words.size());
            err_cnt++;
        end

        $display("Ran %0d commands; checked %0d count replies and %0d expiry words.",
                 n_accepted, n_reads, n_expiries);
        $display("Widest expiry burst from one tick: %0d words; %0d errors.",
                 widest_burst, err_cnt);
        if (err_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/artb_pkg.sv
hw/rtl/artb_ram.sv
hw/rtl/artb_step.sv
hw/rtl/auto_reload_timer_bank.sv
tb/sv/auto_reload_timer_bank_test.sv
